/* rtl/fifo_replacement_key_value_cache_defines.svh */
// ----------------------------------------------------------------------------
// fifo_replacement_key_value_cache_defines.svh
// Assertion macros shared by the cache RTL. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef FIFO_REPLACEMENT_KEY_VALUE_CACHE_DEFINES_SVH
`define FIFO_REPLACEMENT_KEY_VALUE_CACHE_DEFINES_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge out of reset.
`define FRKV_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define FRKV_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FRKV_ASSERT(lbl, clk, rstn, prop, msg)
`define FRKV_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

/* rtl/frkv_pkg.sv */
// ----------------------------------------------------------------------------
// frkv_pkg
// Sizes, request codes and helper functions of the FIFO replacement cache.
// ----------------------------------------------------------------------------
package frkv_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;

    // Fixed port widths.
    localparam int REQ_PORT_W   = 2;
    localparam int KEY_PORT_W   = 32;
    localparam int VALUE_PORT_W = 32;
    localparam int COUNT_PORT_W = 5;

    // Stored widths: only the low bits of a port word are kept.
    localparam int KEY_W   = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
    localparam int VALUE_W = (VALUE_BITS < VALUE_PORT_W) ? VALUE_BITS : VALUE_PORT_W;
    localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int COUNT_W = $clog2(ENTRIES + 1);
    localparam int LINE_W  = KEY_W + VALUE_W;

    typedef logic [REQ_PORT_W-1:0] t_req;
    typedef logic [SLOT_W-1:0]     t_slot;
    typedef logic [COUNT_W-1:0]    t_count;

    localparam t_req REQ_LOOKUP = 2'd0;
    localparam t_req REQ_PUT    = 2'd1;
    localparam t_req REQ_CLEAR  = 2'd2;
    localparam t_req REQ_NOP    = 2'd3;

    // A capacity of zero means one entry; anything above the slot count means all.
    function automatic t_count clamp_capacity(logic [COUNT_PORT_W-1:0] v);
        t_count c;
        if (v == '0) begin
            c = COUNT_W'(1);
        end else if (int'(v) > ENTRIES) begin
            c = COUNT_W'(ENTRIES);
        end else begin
            c = COUNT_W'(v);
        end
        return c;
    endfunction

endpackage

/* rtl/frkv_ram.sv */
// ----------------------------------------------------------------------------
// frkv_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module frkv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/fifo_replacement_key_value_cache.sv */
// ----------------------------------------------------------------------------
// fifo_replacement_key_value_cache
// Fully associative key/value store with first-in-first-out replacement.
// ----------------------------------------------------------------------------
// Usage. A request enters on the input channel (i_in_valid / o_in_ready) with a
// request type, a key and a write value. Lookup returns found and the stored
// value; put updates a present key in place or inserts a new one, evicting the
// oldest entry when the store holds capacity entries; clear empties the store.
// Each request produces exactly one response on the output channel
// (o_out_valid / i_out_ready) carrying found, read_value and the occupancy
// after the request. The capacity register is written through i_cfg_we and
// i_cfg_wdata, takes effect only while the store is empty, and resets to 16.
// Timing. Keys and values share one RAM with a registered read. Lookup and put
// scan the slots one per cycle, stopping at the slot that holds the key or, on a
// miss, at the last slot in use; clear and the unused code skip the scan. The
// response appears in the cycle after the commit step. The response sits in an
// output register, so the block accepts the next request while it waits; if
// the receiver stalls, the following request waits in its commit step until
// the register frees up.
// Reset (synchronous, active low) empties the store and idles the channels;
// the RAM contents are left alone since no valid mark points at them.
// ----------------------------------------------------------------------------
`include "fifo_replacement_key_value_cache_defines.svh"

module fifo_replacement_key_value_cache (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port.
    input  logic                               i_cfg_we,
    input  logic [frkv_pkg::COUNT_PORT_W-1:0]  i_cfg_wdata,
    // Request channel.
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [frkv_pkg::REQ_PORT_W-1:0]    i_req_type,
    input  logic [frkv_pkg::KEY_PORT_W-1:0]    i_key,
    input  logic [frkv_pkg::VALUE_PORT_W-1:0]  i_write_value,
    // Response channel.
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_found,
    output logic [frkv_pkg::VALUE_PORT_W-1:0]  o_read_value,
    output logic [frkv_pkg::COUNT_PORT_W-1:0]  o_occupancy
);

    import frkv_pkg::*;

    localparam int SUM_W = COUNT_W + 1;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_COMMIT = 3'b100
    } t_state;

    // Control state.
    t_state             r_state, n_state;
    logic [ENTRIES-1:0] r_valid, n_valid;
    t_slot              r_oldest, n_oldest;
    t_count             r_count, n_count;
    t_count             r_cap, n_cap;
    logic               r_out_valid;

    // Scan bookkeeping.
    t_slot r_addr;
    logic  r_issue_done;
    logic  r_pend;
    t_slot r_pend_addr;
    logic  r_hit;
    t_slot r_hit_slot;

    // Request and response payload.
    t_req               r_req;
    logic [KEY_W-1:0]   r_key;
    logic [VALUE_W-1:0] r_wval;
    logic [VALUE_W-1:0] r_hit_val;
    logic               r_found;
    logic [VALUE_W-1:0] r_rdval;
    t_count             r_occ;

    // RAM port signals.
    logic              ram_we;
    t_slot             ram_waddr;
    logic              ram_re;
    logic [LINE_W-1:0] ram_rdata;
    logic [KEY_W-1:0]  rd_key;
    logic [VALUE_W-1:0] rd_val;

    // Datapath.
    logic               in_go;
    logic               scan_req;
    logic               cmp_hit;
    logic               scan_end;
    logic               commit_go;
    logic               full;
    t_count             cap_m1;
    t_slot              last_slot;
    logic [SUM_W-1:0]   pos_sum;
    logic [SUM_W-1:0]   next_sum;
    t_slot              ins_pos;
    t_slot              oldest_next;
    logic               n_found;
    logic [VALUE_W-1:0] n_rdval;

    // The scan runs over the slots in use, 0 to capacity - 1.
    assign cap_m1    = r_cap - COUNT_W'(1);
    assign last_slot = cap_m1[SLOT_W-1:0];

    assign o_in_ready = (r_state == S_IDLE);
    assign in_go      = i_in_valid && o_in_ready;
    assign scan_req   = (t_req'(i_req_type) == REQ_LOOKUP) || (t_req'(i_req_type) == REQ_PUT);

    assign rd_key  = ram_rdata[LINE_W-1:VALUE_W];
    assign rd_val  = ram_rdata[VALUE_W-1:0];
    assign cmp_hit = r_pend && r_valid[r_pend_addr] && (rd_key == r_key);
    assign scan_end = r_pend && (cmp_hit || (r_pend_addr == last_slot));

    assign ram_re = (r_state == S_SCAN) && !r_issue_done;

    // The commit step waits only while an older response is still unclaimed.
    assign commit_go = (r_state == S_COMMIT) && (!r_out_valid || i_out_ready);

    // Insertion point: the newest ring position after the oldest entry.
    assign full     = (r_count >= r_cap);
    assign pos_sum  = SUM_W'(r_oldest) + SUM_W'(r_count);
    assign next_sum = SUM_W'(r_oldest) + SUM_W'(1);
    always_comb begin
        if (pos_sum >= SUM_W'(r_cap)) begin
            ins_pos = SLOT_W'(pos_sum - SUM_W'(r_cap));
        end else begin
            ins_pos = pos_sum[SLOT_W-1:0];
        end
        if (next_sum >= SUM_W'(r_cap)) begin
            oldest_next = '0;
        end else begin
            oldest_next = next_sum[SLOT_W-1:0];
        end
    end

    // A put on a hit rewrites its slot. A put on a miss in a full store
    // evicts the oldest entry and reuses its slot, which is exactly the
    // newest ring position once the oldest mark moves on.
    assign ram_we    = commit_go && (r_req == REQ_PUT);
    assign ram_waddr = r_hit ? r_hit_slot : (full ? r_oldest : ins_pos);

    frkv_ram #(
        .WIDTH (LINE_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({r_key, r_wval}),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // Next control state and the response of the request being committed.
    always_comb begin
        n_state  = r_state;
        n_valid  = r_valid;
        n_oldest = r_oldest;
        n_count  = r_count;
        n_cap    = r_cap;
        n_found  = 1'b0;
        n_rdval  = '0;

        case (r_state)
            S_IDLE: begin
                if (in_go) begin
                    n_state = scan_req ? S_SCAN : S_COMMIT;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (commit_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        case (r_req)
            REQ_LOOKUP: begin
                n_found = r_hit;
                n_rdval = r_hit ? r_hit_val : '0;
            end
            REQ_PUT: begin
                n_found = r_hit;
                if (commit_go && !r_hit) begin
                    if (full) begin
                        // Count and the reused slot's valid mark stay as they are.
                        n_oldest = oldest_next;
                    end else begin
                        n_valid[ins_pos] = 1'b1;
                        n_count = r_count + COUNT_W'(1);
                    end
                end
            end
            REQ_CLEAR: begin
                if (commit_go) begin
                    n_valid  = '0;
                    n_oldest = '0;
                    n_count  = '0;
                end
            end
            default: begin
                // The unused request code changes nothing.
            end
        endcase

        // Capacity changes only on an empty store and restarts the ring.
        if (i_cfg_we && (r_count == '0)) begin
            n_cap    = clamp_capacity(i_cfg_wdata);
            n_oldest = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_oldest    <= '0;
            r_count     <= '0;
            r_cap       <= clamp_capacity(COUNT_PORT_W'(16));
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_oldest <= n_oldest;
            r_count  <= n_count;
            r_cap    <= n_cap;
            if (commit_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_pend <= ram_re;
        end
    end

    // Request capture, scan pointers and the response register.
    always_ff @(posedge i_clk) begin
        if (in_go) begin
            r_req        <= t_req'(i_req_type);
            r_key        <= i_key[KEY_W-1:0];
            r_wval       <= i_write_value[VALUE_W-1:0];
            r_hit        <= 1'b0;
            r_addr       <= '0;
            r_issue_done <= 1'b0;
        end else begin
            if (ram_re) begin
                r_pend_addr <= r_addr;
                if (r_addr == last_slot) begin
                    r_issue_done <= 1'b1;
                end else begin
                    r_addr <= r_addr + SLOT_W'(1);
                end
            end
            if ((r_state == S_SCAN) && cmp_hit) begin
                r_hit      <= 1'b1;
                r_hit_slot <= r_pend_addr;
                r_hit_val  <= rd_val;
            end
        end
        if (commit_go) begin
            r_found <= n_found;
            r_rdval <= n_rdval;
            r_occ   <= n_count;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_found      = r_found;
    assign o_read_value = VALUE_PORT_W'(r_rdval);
    assign o_occupancy  = COUNT_PORT_W'(r_occ);

    // The valid marks and the entry count describe the same set of slots.
    `FRKV_ASSERT(a_count_matches_valid, i_clk, i_rst_n,
        $countones(r_valid) == int'(r_count), "entry count differs from valid marks")
    `FRKV_ASSERT(a_count_within_cap, i_clk, i_rst_n,
        r_count <= r_cap, "entry count exceeds capacity")
    `FRKV_ASSERT(a_oldest_within_cap, i_clk, i_rst_n,
        SUM_W'(r_oldest) < SUM_W'(r_cap), "oldest slot outside the ring")
    `FRKV_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n,
        commit_go && (r_req == REQ_CLEAR), (r_count == '0) && (r_valid == '0),
        "clear left entries behind")

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the FIFO replacement key/value cache.
// A queue-fed driver sends lookup, put, clear and unused-code requests, and a
// monitor predicts each response from a shadow copy of the slot ring. It then
// compares every accepted response field by field, in order. The run starts
// with a short directed sequence and then steps through capacity settings and
// idle patterns. Each phase is a burst of random requests over a small key pool.
// ----------------------------------------------------------------------------
module tb;

    import frkv_pkg::*;

    // One request as it travels on the input channel.
    typedef struct {
        t_req                    req_type;
        logic [KEY_PORT_W-1:0]   key;
        logic [VALUE_PORT_W-1:0] write_value;
    } t_request;

    // One response as it is expected on the output channel.
    typedef struct {
        logic                    found;
        logic [VALUE_PORT_W-1:0] read_value;
        logic [COUNT_PORT_W-1:0] occupancy;
    } t_response;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_cfg_we      = 1'b0;
    logic [COUNT_PORT_W-1:0] i_cfg_wdata   = '0;
    logic                    i_in_valid    = 1'b0;
    logic                    o_in_ready;
    logic [REQ_PORT_W-1:0]   i_req_type    = REQ_LOOKUP;
    logic [KEY_PORT_W-1:0]   i_key         = '0;
    logic [VALUE_PORT_W-1:0] i_write_value = '0;
    logic                    o_out_valid;
    logic                    i_out_ready   = 1'b0;
    logic                    o_found;
    logic [VALUE_PORT_W-1:0] o_read_value;
    logic [COUNT_PORT_W-1:0] o_occupancy;

    fifo_replacement_key_value_cache DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_key         (i_key),
        .i_write_value (i_write_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_found       (o_found),
        .o_read_value  (o_read_value),
        .o_occupancy   (o_occupancy)
    );

    // Requests that are waiting to be driven, and responses that are still due.
    t_request  pending_requests[$];
    t_response expected_responses[$];
    logic [KEY_PORT_W-1:0] key_pool[$];

    int   error_count        = 0;
    int   sender_idle_pct    = 0;
    int   receiver_stall_pct = 0;
    logic in_fire            = 1'b0;
    t_request next_request;

    // Shadow copy of the cache state. It follows the accepted requests in order.
    logic [KEY_W-1:0]   shadow_key[ENTRIES];
    logic [VALUE_W-1:0] shadow_value[ENTRIES];
    logic               shadow_live[ENTRIES];
    t_slot              shadow_head;
    t_count             shadow_count;
    t_count             shadow_capacity;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // This is a hard stop in case a response never arrives. It allows many
    // times the slowest legal run: every request scanning the full ring while
    // the receiver stalls for long stretches.
    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // The ring wraps at the configured capacity, not at the physical slot count.
    function automatic t_slot ring_advance(input t_slot idx);
        int nxt;
        nxt = int'(idx) + 1;
        return (nxt >= int'(shadow_capacity)) ? t_slot'(0) : t_slot'(nxt);
    endfunction

    function automatic void empty_shadow();
        for (int i = 0; i < ENTRIES; i++) begin
            shadow_live[i] = 1'b0;
        end
        shadow_head  = '0;
        shadow_count = '0;
    endfunction

    // A capacity write counts only while the store is empty. A zero means one
    // entry, and anything above the slot count means all slots.
    function automatic void apply_capacity_write(input logic [COUNT_PORT_W-1:0] word);
        if (shadow_count != 0) begin
            return;
        end
        if (word == 0) begin
            shadow_capacity = t_count'(1);
        end else if (int'(word) > ENTRIES) begin
            shadow_capacity = t_count'(ENTRIES);
        end else begin
            shadow_capacity = t_count'(word);
        end
        shadow_head = '0;
    endfunction

    // Works out the response to one request and updates the shadow state.
    function automatic t_response predict_response(input t_request req);
        t_response        rsp;
        int               hit;
        t_slot            pos;
        logic [KEY_W-1:0] k;
        k   = req.key[KEY_W-1:0];
        hit = -1;
        rsp.found      = 1'b0;
        rsp.read_value = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (hit < 0 && shadow_live[i] && shadow_key[i] == k) begin
                hit = i;
            end
        end
        case (req.req_type)
            REQ_LOOKUP: begin
                if (hit >= 0) begin
                    rsp.found      = 1'b1;
                    rsp.read_value = VALUE_PORT_W'(shadow_value[hit]);
                end
            end
            REQ_PUT: begin
                if (hit >= 0) begin
                    // An update to a present key keeps its place in the ring.
                    rsp.found         = 1'b1;
                    shadow_value[hit] = req.write_value[VALUE_W-1:0];
                end else begin
                    // When the store is full, the oldest entry goes first and
                    // the new pair lands just past the newest one.
                    if (shadow_count >= shadow_capacity && shadow_count > 0) begin
                        shadow_live[shadow_head] = 1'b0;
                        shadow_head  = ring_advance(shadow_head);
                        shadow_count = shadow_count - 1'b1;
                    end
                    pos = shadow_head;
                    for (int j = 0; j < int'(shadow_count); j++) begin
                        pos = ring_advance(pos);
                    end
                    shadow_key[pos]   = k;
                    shadow_value[pos] = req.write_value[VALUE_W-1:0];
                    shadow_live[pos]  = 1'b1;
                    shadow_count      = shadow_count + 1'b1;
                end
            end
            REQ_CLEAR: begin
                empty_shadow();
            end
            default: begin
                // The unused code has no effect and reports the occupancy.
            end
        endcase
        rsp.occupancy = COUNT_PORT_W'(shadow_count);
        return rsp;
    endfunction

    task automatic push_request(input t_req kind, input logic [KEY_PORT_W-1:0] key,
                                input logic [VALUE_PORT_W-1:0] value);
        t_request r;
        r.req_type    = kind;
        r.key         = key;
        r.write_value = value;
        pending_requests.push_back(r);
    endtask

    // Most keys come from a pool a little larger than the capacity. That gives
    // frequent hits, in-place updates and evictions. The rest are fully random.
    function automatic t_request random_request();
        t_request r;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 45) begin
            r.req_type = REQ_LOOKUP;
        end else if (pick < 94) begin
            r.req_type = REQ_PUT;
        end else if (pick < 98) begin
            r.req_type = REQ_NOP;
        end else begin
            r.req_type = REQ_CLEAR;
        end
        if ($urandom_range(99) < 85) begin
            r.key = key_pool[$urandom_range(key_pool.size() - 1)];
        end else begin
            r.key = $urandom();
        end
        r.write_value = $urandom();
        return r;
    endfunction

    // Blocks until nothing is waiting to be sent and no response is still due.
    // The check runs at the falling edge, after the monitor has taken its sample.
    task automatic drain_requests();
        do begin
            @(negedge i_clk);
        end while (pending_requests.size() != 0 || expected_responses.size() != 0
                   || i_in_valid);
    endtask

    // Lets the block go idle, writes the capacity, and then queues a burst
    // of random requests under the given idle pattern. Every phase ends
    // with a clear, so the next capacity write takes effect.
    task automatic run_phase(input logic [COUNT_PORT_W-1:0] cap_word, input int sender_pct,
                             input int stall_pct, input int n_items);
        drain_requests();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap_word;
        apply_capacity_write(cap_word);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = stall_pct;
        key_pool.delete();
        for (int i = 0; i < int'(shadow_capacity) + 3; i++) begin
            key_pool.push_back($urandom());
        end
        for (int i = 0; i < n_items; i++) begin
            pending_requests.push_back(random_request());
        end
        push_request(REQ_CLEAR, $urandom(), $urandom());
    endtask

    // Request driver. It changes inputs only at the falling edge. It loads the
    // next request once the current one was taken at the last rising edge.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        if (!i_in_valid || in_fire) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                next_request   = pending_requests.pop_front();
                i_in_valid    <= 1'b1;
                i_req_type    <= next_request.req_type;
                i_key         <= next_request.key;
                i_write_value <= next_request.write_value;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Response monitor. It samples both channels at the rising edge. It checks
    // a delivered response against the oldest expectation. It then predicts
    // the response to a newly accepted request.
    always @(posedge i_clk) begin
        in_fire <= i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_responses.size() == 0) begin
                    report_mismatch("response with no request outstanding");
                end else begin
                    t_response want;
                    want = expected_responses.pop_front();
                    if (o_found !== want.found) begin
                        report_mismatch($sformatf("found got %b want %b",
                                                  o_found, want.found));
                    end
                    if (o_read_value !== want.read_value) begin
                        report_mismatch($sformatf("read_value got %h want %h",
                                                  o_read_value, want.read_value));
                    end
                    if (o_occupancy !== want.occupancy) begin
                        report_mismatch($sformatf("occupancy got %0d want %0d",
                                                  o_occupancy, want.occupancy));
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                t_request taken;
                taken.req_type    = i_req_type;
                taken.key         = i_key;
                taken.write_value = i_write_value;
                expected_responses.push_back(predict_response(taken));
            end
        end
    end

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            shadow_key[i]   = '0;
            shadow_value[i] = '0;
        end
        empty_shadow();
        shadow_capacity = t_count'(ENTRIES);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening at the reset capacity. It covers a miss on an
        // empty store, the all-zero and all-one keys and values, an in-place
        // update, a miss on a non-empty store, the unused code, a clear, and
        // a lookup after the clear.
        push_request(REQ_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
        push_request(REQ_PUT,    32'h0000_0000, 32'hFFFF_FFFF);
        push_request(REQ_PUT,    32'hFFFF_FFFF, 32'h0000_0000);
        push_request(REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        push_request(REQ_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_request(REQ_PUT,    32'h0000_0000, 32'hAAAA_AAAA);
        push_request(REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        push_request(REQ_LOOKUP, 32'h1234_5678, 32'h0000_0000);
        push_request(REQ_NOP,    32'hFFFF_FFFF, 32'h5555_5555);
        push_request(REQ_CLEAR,  32'h0000_0000, 32'h0000_0000);
        push_request(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        push_request(REQ_PUT,    32'h0000_0005, 32'hA5A5_A5A5);
        push_request(REQ_PUT,    32'h0000_0006, 32'h5A5A_5A5A);

        // The store still holds two entries here, so the block must ignore
        // the first capacity write and keep the full ring.
        run_phase(5'd3,  0,  0,  60);
        // A written zero means a capacity of one, and 31 is clamped to the
        // slot count. The phases cycle through the idle patterns.
        run_phase(5'd0,  57, 0,  50);
        run_phase(5'd31, 0,  57, 60);
        run_phase(5'd2,  34, 34, 50);
        run_phase(5'd5,  0,  0,  40);
        run_phase(5'd17, 57, 0,  50);
        run_phase(5'd1,  0,  57, 40);
        run_phase(5'd16, 34, 34, 50);

        drain_requests();
        // Keep the clock running so that a stray extra response is seen.
        repeat (30) @(posedge i_clk);
        if (expected_responses.size() != 0) begin
            report_mismatch("responses still outstanding at end of run");
        end
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/frkv_pkg.sv
rtl/frkv_ram.sv
rtl/fifo_replacement_key_value_cache.sv
sim/tb.sv
